/* sv/sbl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sbl_pkg;

  // Number of entries the sorted store can hold.
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int VALUE_W  = 8;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_FULL      = 2'd1,
    ST_DELETED   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // Broadcast from the top level to every cell of the chain.
  typedef struct packed {
    logic               ins;
    logic               del;
    logic [VALUE_W-1:0] value;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* sv/sbl_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface sbl_in_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [sbl_pkg::VALUE_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface sbl_out_if;
  logic                         valid;
  logic                         ready;
  logic [sbl_pkg::STATUS_W-1:0] status;
  logic [sbl_pkg::COUNT_W-1:0]  entry_count;
  logic [sbl_pkg::VALUE_W-1:0]  smallest_value;

  modport source (output valid, output status, output entry_count, output smallest_value,
                  input ready);
  modport sink   (input valid, input status, input entry_count, input smallest_value,
                  output ready);
endinterface

`default_nettype wire

/* sv/sbl_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module sbl_cell (
  input  wire                        clk_i,
  input  wire sbl_pkg::cell_ctl_t    ctl_i,
  input  wire                        occupied_i,
  input  wire                        left_lt_i,
  input  wire [sbl_pkg::VALUE_W-1:0] left_val_i,
  input  wire [sbl_pkg::VALUE_W-1:0] right_val_i,
  output logic                       lt_o,
  output logic                       match_o,
  output logic [sbl_pkg::VALUE_W-1:0] val_o,
  output logic [sbl_pkg::VALUE_W-1:0] val_next_o
);

  logic [sbl_pkg::VALUE_W-1:0] val_q;
  logic [sbl_pkg::VALUE_W-1:0] val_d;
  logic                        at_pos;

  // This cell is the insertion point when it is the first one not below the value.
  assign lt_o    = occupied_i && (val_q < ctl_i.value);
  assign at_pos  = !lt_o && left_lt_i;
  assign match_o = occupied_i && at_pos && (val_q == ctl_i.value);

  always_comb begin
    val_d = val_q;
    if (ctl_i.ins && !lt_o) begin
      val_d = at_pos ? ctl_i.value : left_val_i;
    end else if (ctl_i.del && !lt_o) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o      = val_q;
  assign val_next_o = val_d;

endmodule

`default_nettype wire

/* sv/sorted_byte_list_insert_delete_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Sorted byte list: keeps up to sbl_pkg::CAPACITY byte values in ascending
// order, duplicates allowed.
// An input transaction on in_chan_i carries an opcode (insert or delete) and
// a byte value. Each input transaction produces exactly one output
// transaction on out_chan_o with the status, the entry count and the
// smallest stored value, all taken after the operation.
// The store is a row of cells, one per entry. Every cell compares the
// broadcast value with its own entry and then keeps its entry, takes the
// new value, or takes its left or right neighbor's entry.
// The result is output in the cycle after its input is accepted, and one
// operation is accepted per cycle while the receiver keeps taking results;
// the result register is the only buffer, so input is accepted whenever
// that register is empty or being drained in the same cycle.
// When the receiver stalls, the result is held and the input side stalls
// with it after one pending result.
// Reset empties the list and clears the result valid flag; entry contents
// are not cleared, since entries beyond the count are never observed.

module sorted_byte_list_insert_delete_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  sbl_in_if.sink      in_chan_i,
  sbl_out_if.source   out_chan_o
);

  localparam int N = sbl_pkg::CAPACITY;

  logic [sbl_pkg::CNT_W-1:0] count_q;
  logic [sbl_pkg::CNT_W-1:0] count_d;

  logic                          out_valid_q;
  logic [sbl_pkg::STATUS_W-1:0]  status_q;
  logic [sbl_pkg::COUNT_W-1:0]   entry_count_q;
  logic [sbl_pkg::VALUE_W-1:0]   smallest_q;

  logic                accept;
  logic                full;
  logic                found;
  sbl_pkg::cell_ctl_t  ctl;
  sbl_pkg::status_e    status_d;

  logic [N-1:0]                 lt;
  logic [N-1:0]                 match;
  logic [N-1:0]                 occupied;
  logic [N-1:0]                 left_lt;
  logic [sbl_pkg::VALUE_W-1:0]  vals     [N];
  logic [sbl_pkg::VALUE_W-1:0]  vals_next[N];
  logic [sbl_pkg::VALUE_W-1:0]  left_val [N];
  logic [sbl_pkg::VALUE_W-1:0]  right_val[N];

  logic [sbl_pkg::CNT_W+sbl_pkg::COUNT_W-1:0] count_ext;

  // The result register frees up when it is empty or its transaction completes.
  assign in_chan_i.ready = !out_valid_q || out_chan_o.ready;
  assign accept          = in_chan_i.valid && in_chan_i.ready;

  assign full  = (count_q == sbl_pkg::CNT_W'(N));
  assign found = |match;

  assign ctl.value = in_chan_i.value;
  assign ctl.ins   = accept && (in_chan_i.opcode == sbl_pkg::OP_INSERT) && !full;
  assign ctl.del   = accept && (in_chan_i.opcode == sbl_pkg::OP_DELETE) && found;

  // Cell neighbor wiring. The first cell sees a left neighbor that is
  // always below the value, so it can be the insertion point.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      occupied[i] = (sbl_pkg::CNT_W'(i) < count_q);
      left_lt[i]  = (i == 0) ? 1'b1 : lt[(i == 0) ? 0 : i - 1];
      left_val[i] = (i == 0) ? in_chan_i.value : vals[(i == 0) ? 0 : i - 1];
      right_val[i] = (i == N - 1) ? '0 : vals[(i == N - 1) ? i : i + 1];
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    sbl_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .occupied_i  (occupied[g]),
      .left_lt_i   (left_lt[g]),
      .left_val_i  (left_val[g]),
      .right_val_i (right_val[g]),
      .lt_o        (lt[g]),
      .match_o     (match[g]),
      .val_o       (vals[g]),
      .val_next_o  (vals_next[g])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = sbl_pkg::ST_NOT_FOUND;
    if (in_chan_i.opcode == sbl_pkg::OP_INSERT) begin
      if (full) begin
        status_d = sbl_pkg::ST_FULL;
      end else begin
        status_d = sbl_pkg::ST_INSERTED;
        count_d  = count_q + 1'b1;
      end
    end else if (found) begin
      status_d = sbl_pkg::ST_DELETED;
      count_d  = count_q - 1'b1;
    end
  end

  // The entry count field wraps at its own width for large capacities.
  assign count_ext = {{sbl_pkg::COUNT_W{1'b0}}, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_chan_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q      <= status_d;
      entry_count_q <= count_ext[sbl_pkg::COUNT_W-1:0];
      smallest_q    <= (count_d != '0) ? vals_next[0] : '0;
    end
  end

  assign out_chan_o.valid          = out_valid_q;
  assign out_chan_o.status         = status_q;
  assign out_chan_o.entry_count    = entry_count_q;
  assign out_chan_o.smallest_value = smallest_q;

`ifndef SYNTHESIS
  // The list never holds more entries than there are cells.
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sbl_pkg::CNT_W'(N))
    else $error("entry count exceeds capacity");

  // Sorted order means at most one cell can be the matching insertion point.
  a_match_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("more than one cell matched a delete");

  // A full rejection leaves the count at capacity.
  a_full_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && full && (in_chan_i.opcode == sbl_pkg::OP_INSERT)
    |=> count_q == sbl_pkg::CNT_W'(N) && status_q == sbl_pkg::ST_FULL)
    else $error("full insert changed the list");

  // The first two stored entries are in ascending order.
  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= sbl_pkg::CNT_W'(2)) |-> vals[0] <= vals[1])
    else $error("first two entries out of order");
`endif

endmodule

`default_nettype wire

/* verif/tb_sorted_byte_list_insert_delete_unit.sv */
`timescale 1ns / 1ps

// The testbench drives list operations into the sorted byte list and checks
// every result transaction against a shadow copy of the list. That copy is
// kept in the testbench and updated at the moment each input transaction is
// accepted.
module tb_sorted_byte_list_insert_delete_unit;

  // Expected content of one result transaction.
  typedef struct {
    sbl_pkg::status_e            status;
    logic [sbl_pkg::COUNT_W-1:0] entry_count;
    logic [sbl_pkg::VALUE_W-1:0] smallest_value;
  } list_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sbl_in_if  in_chan ();
  sbl_out_if out_chan ();

  sorted_byte_list_insert_delete_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan_i  (in_chan),
    .out_chan_o (out_chan)
  );

  // Shadow of the sorted store. Only entries below shadow_count are ever read.
  logic [sbl_pkg::VALUE_W-1:0] shadow_list [sbl_pkg::CAPACITY];
  int                          shadow_count = 0;

  // Results still owed by the block, oldest first.
  list_result_t pending_results [$];

  int  mismatch_count = 0;
  // Set for the last part of the run. Neither side idles after that point.
  bit  idle_off = 1'b0;
  int  sent_count = 0;
  bit  sender_calm = 1'b0;

  // The clock period is 10 ns. Both phases last 5 ns.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Every input has a known value from time zero. The receiver is held off
  // until reset has been released.
  initial begin
    in_chan.valid  = 1'b0;
    in_chan.opcode = sbl_pkg::OP_INSERT;
    in_chan.value  = '0;
    out_chan.ready = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Apply one operation to the shadow list and queue the result it must
  // produce. This mirrors the block: an insert goes in front of the first
  // entry that is not smaller, and a delete removes the first equal entry.
  task automatic apply_list_op(input sbl_pkg::opcode_e op,
                               input logic [sbl_pkg::VALUE_W-1:0] v);
    int           pos;
    list_result_t res;
    pos = 0;
    while (pos < shadow_count && shadow_list[pos] < v) pos++;
    if (op == sbl_pkg::OP_INSERT) begin
      if (shadow_count >= sbl_pkg::CAPACITY) begin
        res.status = sbl_pkg::ST_FULL;
      end else begin
        for (int k = shadow_count; k > pos; k--) shadow_list[k] = shadow_list[k-1];
        shadow_list[pos] = v;
        shadow_count++;
        res.status = sbl_pkg::ST_INSERTED;
      end
    end else begin
      if (pos < shadow_count && shadow_list[pos] == v) begin
        for (int k = pos; k + 1 < shadow_count; k++) shadow_list[k] = shadow_list[k+1];
        shadow_count--;
        res.status = sbl_pkg::ST_DELETED;
      end else begin
        res.status = sbl_pkg::ST_NOT_FOUND;
      end
    end
    res.entry_count    = shadow_count[sbl_pkg::COUNT_W-1:0];
    res.smallest_value = (shadow_count > 0) ? shadow_list[0] : '0;
    pending_results.push_back(res);
  endtask

  // Send one input transaction. The task is entered and left at a falling
  // edge. Valid is written once per time step. A gap lowers it at this edge
  // and raises it again at a later edge, so valid stays high across
  // back-to-back items.
  task automatic send_op(input sbl_pkg::opcode_e op, input logic [sbl_pkg::VALUE_W-1:0] v);
    int gap;
    if (sent_count % 64 == 0) sender_calm = ($urandom_range(0, 2) == 0);
    sent_count++;
    gap = 0;
    if (!idle_off && !sender_calm && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 18);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_chan.valid  <= 1'b1;
    in_chan.opcode <= op;
    in_chan.value  <= v;
    // Ready is sampled at the rising edge, before the block updates.
    do @(posedge clk_i); while (!in_chan.ready);
    apply_list_op(op, v);
    @(negedge clk_i);
  endtask

  // Clustered values fall near both ends of the byte range. They collide
  // often, which exercises duplicates and equal-value ordering.
  function automatic logic [sbl_pkg::VALUE_W-1:0] pick_value(input bit clustered);
    if (clustered)
      return sbl_pkg::VALUE_W'($urandom_range(0, 5) + ($urandom_range(0, 1) ? 250 : 0));
    return sbl_pkg::VALUE_W'($urandom_range(0, 255));
  endfunction

  // Choose a value for a delete. Most deletes target an entry that is
  // present. The rest are random and usually miss.
  function automatic logic [sbl_pkg::VALUE_W-1:0] pick_delete_value(input bit clustered);
    if (shadow_count > 0 && $urandom_range(0, 3) != 0)
      return shadow_list[$urandom_range(0, shadow_count - 1)];
    return pick_value(clustered);
  endfunction

  // ---------------------------------------------------------------------
  // Test tasks
  // ---------------------------------------------------------------------

  // Deletes on an empty list must report not found. The count stays zero
  // and the smallest value reads as zero.
  task automatic test_empty_list_delete();
    send_op(sbl_pkg::OP_DELETE, 8'd0);
    send_op(sbl_pkg::OP_DELETE, 8'd255);
  endtask

  // Extreme values and a duplicate go in. Zero is then deleted twice, which
  // drops both copies, and a value that is absent is deleted once.
  task automatic test_extremes_and_zero();
    send_op(sbl_pkg::OP_INSERT, 8'd0);
    send_op(sbl_pkg::OP_INSERT, 8'd255);
    send_op(sbl_pkg::OP_INSERT, 8'd0);
    send_op(sbl_pkg::OP_INSERT, 8'd7);
    send_op(sbl_pkg::OP_DELETE, 8'd0);
    send_op(sbl_pkg::OP_DELETE, 8'd0);
    send_op(sbl_pkg::OP_DELETE, 8'd9);
  endtask

  // Fill the list to capacity and insert once more, which must be rejected
  // as full. Inserts at the front, at the back and between equal values all
  // move entries. A delete then frees one slot.
  task automatic test_fill_to_capacity();
    logic [sbl_pkg::VALUE_W-1:0] fill [14] = '{8'd200, 8'd1, 8'd255, 8'd0, 8'd128, 8'd7,
                                               8'd127, 8'd6, 8'd254, 8'd0, 8'd85, 8'd170,
                                               8'd3, 8'd255};
    foreach (fill[i]) send_op(sbl_pkg::OP_INSERT, fill[i]);
    send_op(sbl_pkg::OP_INSERT, 8'd100);
    send_op(sbl_pkg::OP_DELETE, 8'd255);
  endtask

  // Random operations. The sequence swings between growing and shrinking,
  // so the list passes through empty, partly filled and full many times.
  // A full list takes a few rejected inserts before it starts shrinking.
  task automatic test_random_ops(input int n_items, input bit clustered);
    bit               growing;
    sbl_pkg::opcode_e op;
    growing = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      if (shadow_count >= sbl_pkg::CAPACITY && $urandom_range(0, 3) == 0) growing = 1'b0;
      else if (shadow_count == 0 && $urandom_range(0, 2) == 0) growing = 1'b1;
      else if ($urandom_range(0, 39) == 0) growing = !growing;
      op = ($urandom_range(0, 99) < (growing ? 75 : 25)) ? sbl_pkg::OP_INSERT
                                                          : sbl_pkg::OP_DELETE;
      if (op == sbl_pkg::OP_INSERT) send_op(op, pick_value(clustered));
      else send_op(op, pick_delete_value(clustered));
    end
  endtask

  // ---------------------------------------------------------------------
  // Result checker: each accepted result transaction is compared with the
  // oldest expectation.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni && out_chan.valid && out_chan.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no operation pending", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_chan.status !== want.status)
          report_mismatch("status", out_chan.status, want.status);
        if (out_chan.entry_count !== want.entry_count)
          report_mismatch("entry_count", out_chan.entry_count, want.entry_count);
        if (out_chan.smallest_value !== want.smallest_value)
          report_mismatch("smallest_value", out_chan.smallest_value, want.smallest_value);
      end
    end
  end

  // Receiver back-pressure. Ready drops in bursts of random length, with
  // calm stretches between them. Every change happens at a falling edge.
  initial begin
    int  cycle;
    bit  calm;
    cycle = 0;
    calm  = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (cycle % 64 == 0) calm = ($urandom_range(0, 2) == 0);
      cycle++;
      if (!idle_off && !calm && $urandom_range(0, 7) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk_i);
        cycle++;
      end
      out_chan.ready <= 1'b1;
    end
  end

  // Watchdog. The worst legal run is about 2000 items, each held up by a
  // sender gap and a receiver stall. That comes to well under 1 ms, so
  // 5 ms leaves a wide margin.
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int waited;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_list_delete();
    test_extremes_and_zero();
    test_fill_to_capacity();
    test_random_ops(900, 1'b0);
    test_random_ops(600, 1'b1);
    // Both sides stop idling for the final stretch.
    idle_off = 1'b1;
    test_random_ops(450, 1'b0);

    in_chan.valid <= 1'b0;

    // Drain the results that are still owed. Each result passes through a
    // single result register, so the bound is generous.
    waited = 0;
    while (pending_results.size() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", 0, pending_results.size());
    // Further waiting catches any result that arrives with nothing pending.
    repeat (8) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
